FILE: sv/sab_pkg.sv
package sab_pkg;

	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 11;
	localparam int POS_W  = 10;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// word index of each register, taken from paddr[ADDR_W-1:2]
	localparam logic REG_ARRAY_LENGTH = 1'b0;

	typedef struct packed {
		logic                    search;
		logic                    wr_ok;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} sab_op_t;

endpackage

FILE: sv/sab_front.sv
module sab_front #(
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             func,
	input  logic [sab_pkg::IDX_W-1:0]        index,
	input  logic signed [sab_pkg::VAL_W-1:0] value,
	output logic                             op_valid,
	output sab_pkg::sab_op_t                 op,
	input  logic                             op_take
);
	import sab_pkg::*;

	sab_op_t     slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        enq;
	logic        deq;
	sab_op_t     op_in;

	// classify the request before it is queued
	always_comb begin
		op_in.search = (func == FUNC_SEARCH);
		op_in.wr_ok  = (32'(index) < 32'(DEPTH));
		op_in.index  = index;
		op_in.value  = value;
	end

	assign full     = (cnt_q == 2'd2);
	assign enq      = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign deq      = op_take && op_valid;
	assign op       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/sab_back.sv
module sab_back #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sab_pkg::LEN_W-1:0]   array_length,
	input  logic                        op_valid,
	input  sab_pkg::sab_op_t            op,
	output logic                        op_take,
	output logic                        empty,
	input  logic                        pop,
	output logic                        found,
	output logic [sab_pkg::POS_W-1:0]   position
);
	import sab_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;

	logic [1:0]              state_q;
	logic [LW-1:0]           lo_q;
	logic [LW-1:0]           hi_q;
	logic [AW-1:0]           mid_q;
	logic signed [VAL_W-1:0] key_q;
	logic                    pend_found_q;
	logic [POS_W-1:0]        pend_pos_q;
	logic                    res_valid_q;
	logic                    found_q;
	logic [POS_W-1:0]        pos_q;

	logic [31:0]             len_ext;
	logic [LW-1:0]           covered;
	logic [LW-1:0]           span;
	logic [AW-1:0]           mid;
	logic                    range_live;
	logic                    mem_we;
	logic                    mem_re;
	logic                    res_load;

	assign len_ext    = 32'(array_length);
	assign covered    = (len_ext > 32'(DEPTH)) ? LW'(DEPTH) : LW'(len_ext);
	assign range_live = (lo_q < hi_q);
	// hi_q is exclusive, so the probe sits at lo + (hi - 1 - lo) / 2
	assign span       = hi_q - lo_q - LW'(1);
	assign mid        = AW'(lo_q + (span >> 1));

	assign op_take  = (state_q == ST_IDLE) && op_valid;
	assign mem_we   = op_take && !op.search && op.wr_ok;
	assign mem_re   = (state_q == ST_PROBE) && range_live;
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || pop);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(op.index)] <= op.value;
		end
		if (mem_re) begin
			rdata_q <= mem[mid];
		end
	end

	always_ff @(posedge clk) begin
		if (op_take && op.search) begin
			lo_q  <= '0;
			hi_q  <= covered;
			key_q <= op.value;
		end
		if (mem_re) begin
			mid_q <= mid;
		end
		if (state_q == ST_CMP && rdata_q != key_q) begin
			if (rdata_q > key_q) begin
				hi_q <= LW'(mid_q);
			end else begin
				lo_q <= LW'(mid_q) + LW'(1);
			end
		end
		if (state_q == ST_PROBE && !range_live) begin
			pend_found_q <= 1'b0;
			pend_pos_q   <= '0;
		end else if (state_q == ST_CMP && rdata_q == key_q) begin
			pend_found_q <= 1'b1;
			pend_pos_q   <= POS_W'(mid_q);
		end
		if (res_load) begin
			found_q <= pend_found_q;
			pos_q   <= pend_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op_take && op.search) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= range_live ? ST_CMP : ST_DONE;
				end
				ST_CMP: begin
					state_q <= (rdata_q == key_q) ? ST_DONE : ST_PROBE;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !res_valid_q;
	assign found    = found_q;
	assign position = pos_q;

endmodule

FILE: sv/sorted_array_binary_search.sv
// Sorted-array binary search. A write request (func = 0) stores value at index; a search
// request (func = 1) bisects entries 0 .. array_length-1 (clipped to DEPTH) for value and
// returns one result: found, and position of the first probe that matched (0 when not
// found). Entries are signed and assumed sorted ascending; only entries already written may
// be probed, and the store needs no clearing after reset. Requests enter a two-entry queue,
// so pushes continue while a search runs or a result waits. The back end has a single
// memory port with a registered read: a write is stored as the request is taken, while a
// search alternates a probe state and a compare state for each probe, then waits in a
// done state until its result can be loaded. array_length sits at byte address 0 of the
// APB port and must be written only while the block is idle.
module sorted_array_binary_search #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              func,
	input  logic [sab_pkg::IDX_W-1:0]         index,
	input  logic signed [sab_pkg::VAL_W-1:0]  value,
	output logic                              empty,
	input  logic                              pop,
	output logic                              found,
	output logic [sab_pkg::POS_W-1:0]         position,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sab_pkg::ADDR_W-1:0]        paddr,
	input  logic [sab_pkg::DATA_W-1:0]        pwdata,
	output logic [sab_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import sab_pkg::*;

	logic [LEN_W-1:0] array_length_q;
	logic             reg_sel;
	logic             op_valid;
	logic             op_take;
	sab_op_t          op;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_ARRAY_LENGTH);
	assign prdata  = reg_sel ? DATA_W'(array_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			array_length_q <= pwdata[LEN_W-1:0];
		end
	end

	sab_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.index    (index),
		.value    (value),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	sab_back #(.DEPTH(DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.array_length (array_length_q),
		.op_valid     (op_valid),
		.op           (op),
		.op_take      (op_take),
		.empty        (empty),
		.pop          (pop),
		.found        (found),
		.position     (position)
	);

endmodule

FILE: sv/sab_checker.sv
module sab_checker #(
	parameter int DEPTH = 1024
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic                        found,
	input logic [sab_pkg::POS_W-1:0]   position
);
	import sab_pkg::*;

	// a miss always reports position zero
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !found |-> position == '0)
		else $error("miss with nonzero position");

	// a hit lies inside the store
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && found |-> (DEPTH > 1024) || (32'(position) < 32'(DEPTH)))
		else $error("hit position beyond store");

	// the request queue only fills on a push
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("queue became full without a push");

	// a waiting result holds until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(found) && $stable(position))
		else $error("waiting result changed");

endmodule

bind sorted_array_binary_search sab_checker #(.DEPTH(DEPTH)) u_sab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.found    (found),
	.position (position)
);
